// ===== design/tnhs_pkg.sv =====
// ============================================================================
// Tiered nearest hand select package
// Shared transaction types, field widths and codes of the hand select core.
// ============================================================================
package tnhs_pkg;

   localparam int COORD_BITS  = 24;
   localparam int PERSON_BITS = 16;
   localparam int SIDE_BITS   = 2;
   localparam int KIND_BITS   = 2;
   localparam int TIER_BITS   = 2;
   localparam int DIST_BITS   = 2 * COORD_BITS + 2;

   localparam logic [KIND_BITS-1:0] KIND_START = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_HAND  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_END   = 2'd2;

   localparam logic [TIER_BITS-1:0] TIER_EXACT  = 2'd0;
   localparam logic [TIER_BITS-1:0] TIER_PERSON = 2'd1;
   localparam logic [TIER_BITS-1:0] TIER_ANY    = 2'd2;
   localparam logic [TIER_BITS-1:0] TIER_NONE   = 2'd3;

   typedef struct packed {
      logic [KIND_BITS-1:0]          kind;
      logic [PERSON_BITS-1:0]        query_person;
      logic [SIDE_BITS-1:0]          query_side;
      logic signed [COORD_BITS-1:0]  near_x;
      logic signed [COORD_BITS-1:0]  near_y;
      logic [PERSON_BITS-1:0]        hand_person;
      logic [SIDE_BITS-1:0]          hand_side;
      logic signed [COORD_BITS-1:0]  hand_x;
      logic signed [COORD_BITS-1:0]  hand_y;
      logic                          hand_finite;
   } req_type;

   typedef struct packed {
      logic                          found;
      logic signed [COORD_BITS-1:0]  center_x;
      logic signed [COORD_BITS-1:0]  center_y;
      logic [TIER_BITS-1:0]          match_tier;
   } rsp_type;

endpackage

// ===== design/tiered_nearest_hand_select_core.sv =====
// ============================================================================
// Tiered nearest hand select core
// Picks one hand center for a query in three priority tiers in one pass.
// ============================================================================
// A start transaction on req loads the person id, the hand side and the
// fallback point, and clears the three candidates. Each finite hand
// transaction then updates the first exact match, the nearest hand of the
// wanted person and the nearest hand overall. An end transaction produces
// one rsp transaction with the best tier's center, or not-found; other
// transactions produce nothing.
// The core is a three stage pipeline: an input register, a stage that holds
// the squared distance of the record, and the rsp output register. One
// transaction is accepted every cycle while req_ready is high. The rsp
// transaction of an end moves from the input register to the second stage,
// and into the output register once it is free. When the receiver stalls,
// the result waits in the output register; an end that reaches the second
// stage while the output is still full waits there, and req_ready drops as
// soon as the input register also holds a transaction, staying low until
// rsp is taken. Reset clears the query, the candidates and all valid bits.
module tiered_nearest_hand_select_core
   import tnhs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   typedef struct packed {
      logic [KIND_BITS-1:0]         kind;
      logic                         finite;
      logic                         person_match;
      logic                         exact_match;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [DIST_BITS-1:0]         sq_dist;
   } stage_type;

   logic                         s1_valid_ff;
   req_type                      s1_item_ff;
   logic                         s2_valid_ff;
   stage_type                    s2_item_ff;
   stage_type                    s2_item_in;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_payload_ff;
   rsp_type                      rsp_payload_in;

   logic [PERSON_BITS-1:0]       want_person_ff;
   logic [SIDE_BITS-1:0]         want_side_ff;
   logic signed [COORD_BITS-1:0] ref_x_ff;
   logic signed [COORD_BITS-1:0] ref_y_ff;

   logic                         exact_hit_ff;
   logic signed [COORD_BITS-1:0] exact_x_ff;
   logic signed [COORD_BITS-1:0] exact_y_ff;
   logic                         person_hit_ff;
   logic [DIST_BITS-1:0]         person_dist_ff;
   logic signed [COORD_BITS-1:0] person_x_ff;
   logic signed [COORD_BITS-1:0] person_y_ff;
   logic                         any_hit_ff;
   logic [DIST_BITS-1:0]         any_dist_ff;
   logic signed [COORD_BITS-1:0] any_x_ff;
   logic signed [COORD_BITS-1:0] any_y_ff;

   logic                         out_free;
   logic                         s2_go;
   logic                         s1_go;
   logic                         s2_fire;
   logic                         hand_fire;
   logic                         person_less;
   logic                         any_less;
   logic [DIST_BITS-1:0]         sq_dist;

   tnhs_sqdist u_sqdist (
      .hand_x  (s1_item_ff.hand_x),
      .hand_y  (s1_item_ff.hand_y),
      .ref_x   (ref_x_ff),
      .ref_y   (ref_y_ff),
      .sq_dist (sq_dist)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_go     = !s2_valid_ff || (s2_item_ff.kind != KIND_END) || out_free;
   assign s1_go     = !s1_valid_ff || s2_go;
   assign req_ready = s1_go;
   assign s2_fire   = s2_valid_ff && s2_go;
   assign hand_fire = s2_fire && (s2_item_ff.kind == KIND_HAND) && s2_item_ff.finite;

   assign person_less = !person_hit_ff || (s2_item_ff.sq_dist < person_dist_ff);
   assign any_less    = !any_hit_ff || (s2_item_ff.sq_dist < any_dist_ff);

   always_comb begin
      s2_item_in.kind         = s1_item_ff.kind;
      s2_item_in.finite       = s1_item_ff.hand_finite;
      s2_item_in.person_match = (s1_item_ff.hand_person == want_person_ff);
      s2_item_in.exact_match  = (s1_item_ff.hand_person == want_person_ff) &&
                                (s1_item_ff.hand_side == want_side_ff);
      s2_item_in.x            = s1_item_ff.hand_x;
      s2_item_in.y            = s1_item_ff.hand_y;
      s2_item_in.sq_dist      = sq_dist;
   end

   always_comb begin
      rsp_payload_in.found      = 1'b1;
      rsp_payload_in.center_x   = '0;
      rsp_payload_in.center_y   = '0;
      rsp_payload_in.match_tier = TIER_NONE;
      if (exact_hit_ff) begin
         rsp_payload_in.center_x   = exact_x_ff;
         rsp_payload_in.center_y   = exact_y_ff;
         rsp_payload_in.match_tier = TIER_EXACT;
      end else if (person_hit_ff) begin
         rsp_payload_in.center_x   = person_x_ff;
         rsp_payload_in.center_y   = person_y_ff;
         rsp_payload_in.match_tier = TIER_PERSON;
      end else if (any_hit_ff) begin
         rsp_payload_in.center_x   = any_x_ff;
         rsp_payload_in.center_y   = any_y_ff;
         rsp_payload_in.match_tier = TIER_ANY;
      end else begin
         rsp_payload_in.found = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s1_item_ff <= req_payload;
      end
      if (s2_go) begin
         s2_item_ff <= s2_item_in;
      end
      if (s2_fire && (s2_item_ff.kind == KIND_END)) begin
         rsp_payload_ff <= rsp_payload_in;
      end
      if (hand_fire && s2_item_ff.exact_match && !exact_hit_ff) begin
         exact_x_ff <= s2_item_ff.x;
         exact_y_ff <= s2_item_ff.y;
      end
      if (hand_fire && s2_item_ff.person_match && person_less) begin
         person_dist_ff <= s2_item_ff.sq_dist;
         person_x_ff    <= s2_item_ff.x;
         person_y_ff    <= s2_item_ff.y;
      end
      if (hand_fire && any_less) begin
         any_dist_ff <= s2_item_ff.sq_dist;
         any_x_ff    <= s2_item_ff.x;
         any_y_ff    <= s2_item_ff.y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         want_person_ff <= '0;
         want_side_ff   <= '0;
         ref_x_ff       <= '0;
         ref_y_ff       <= '0;
         exact_hit_ff   <= 1'b0;
         person_hit_ff  <= 1'b0;
         any_hit_ff     <= 1'b0;
      end else begin
         if (s1_go) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_go) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s2_fire && (s2_item_ff.kind == KIND_END)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && s2_go && (s1_item_ff.kind == KIND_START)) begin
            want_person_ff <= s1_item_ff.query_person;
            want_side_ff   <= s1_item_ff.query_side;
            ref_x_ff       <= s1_item_ff.near_x;
            ref_y_ff       <= s1_item_ff.near_y;
         end
         if (s2_fire && (s2_item_ff.kind == KIND_START)) begin
            exact_hit_ff  <= 1'b0;
            person_hit_ff <= 1'b0;
            any_hit_ff    <= 1'b0;
         end else if (hand_fire) begin
            if (s2_item_ff.exact_match) begin
               exact_hit_ff <= 1'b1;
            end
            if (s2_item_ff.person_match) begin
               person_hit_ff <= 1'b1;
            end
            any_hit_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTH
   a_exact_implies_person: assert property (@(posedge clock) disable iff (reset)
      exact_hit_ff |-> person_hit_ff)
      else $error("exact candidate without a person candidate");

   a_person_implies_any: assert property (@(posedge clock) disable iff (reset)
      person_hit_ff |-> any_hit_ff)
      else $error("person candidate without an overall candidate");

   a_any_nearest: assert property (@(posedge clock) disable iff (reset)
      (person_hit_ff && any_hit_ff) |-> (any_dist_ff <= person_dist_ff))
      else $error("overall candidate farther than person candidate");

   a_end_held: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (s2_item_ff.kind == KIND_END) && !out_free)
      |=> (s2_valid_ff && (s2_item_ff.kind == KIND_END)))
      else $error("end transaction lost while output was full");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.found) |->
      ((rsp_payload_ff.match_tier == TIER_NONE) && (rsp_payload_ff.center_x == '0) &&
       (rsp_payload_ff.center_y == '0)))
      else $error("not-found result carries a center");
`endif

endmodule

// ===== design/tnhs_sqdist.sv =====
// ============================================================================
// Squared distance unit
// Squared Euclidean distance between a hand center and the fallback point.
// ============================================================================
module tnhs_sqdist
   import tnhs_pkg::*;
(
   input  logic signed [COORD_BITS-1:0] hand_x,
   input  logic signed [COORD_BITS-1:0] hand_y,
   input  logic signed [COORD_BITS-1:0] ref_x,
   input  logic signed [COORD_BITS-1:0] ref_y,
   output logic [DIST_BITS-1:0]         sq_dist
);

   logic signed [COORD_BITS:0] diff_x;
   logic signed [COORD_BITS:0] diff_y;
   logic [COORD_BITS:0]        mag_x;
   logic [COORD_BITS:0]        mag_y;
   logic [DIST_BITS-1:0]       sq_x;
   logic [DIST_BITS-1:0]       sq_y;

   assign diff_x  = {hand_x[COORD_BITS-1], hand_x} - {ref_x[COORD_BITS-1], ref_x};
   assign diff_y  = {hand_y[COORD_BITS-1], hand_y} - {ref_y[COORD_BITS-1], ref_y};
   assign mag_x   = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : diff_x;
   assign mag_y   = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : diff_y;
   assign sq_x    = DIST_BITS'(mag_x) * DIST_BITS'(mag_x);
   assign sq_y    = DIST_BITS'(mag_y) * DIST_BITS'(mag_y);
   assign sq_dist = sq_x + sq_y;

endmodule

// ===== dv/tnhs_result_checker.sv =====
// ============================================================================
// Tiered nearest hand select result checker
// Watches both channels of the hand select core, predicts each result from
// the accepted request transactions and compares it field by field.
// ============================================================================
module tnhs_result_checker
   import tnhs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [PERSON_BITS-1:0]       want_person;
   logic [SIDE_BITS-1:0]         want_side;
   logic signed [COORD_BITS-1:0] anchor_x;
   logic signed [COORD_BITS-1:0] anchor_y;
   logic                         exact_hit;
   logic signed [COORD_BITS-1:0] exact_x;
   logic signed [COORD_BITS-1:0] exact_y;
   logic                         person_hit;
   logic [DIST_BITS-1:0]         person_dist;
   logic signed [COORD_BITS-1:0] person_x;
   logic signed [COORD_BITS-1:0] person_y;
   logic                         any_hit;
   logic [DIST_BITS-1:0]         any_dist;
   logic signed [COORD_BITS-1:0] any_x;
   logic signed [COORD_BITS-1:0] any_y;

   rsp_type selection_queue[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   function automatic logic [DIST_BITS-1:0] squared_distance(
      input logic signed [COORD_BITS-1:0] ax,
      input logic signed [COORD_BITS-1:0] ay,
      input logic signed [COORD_BITS-1:0] bx,
      input logic signed [COORD_BITS-1:0] by
   );
      logic [COORD_BITS:0]  dx;
      logic [COORD_BITS:0]  dy;
      logic [DIST_BITS-1:0] px;
      logic [DIST_BITS-1:0] py;
      dx = {ax[COORD_BITS-1], ax} - {bx[COORD_BITS-1], bx};
      dy = {ay[COORD_BITS-1], ay} - {by[COORD_BITS-1], by};
      if (dx[COORD_BITS]) begin
         dx = -dx;
      end
      if (dy[COORD_BITS]) begin
         dy = -dy;
      end
      px = DIST_BITS'(dx) * DIST_BITS'(dx);
      py = DIST_BITS'(dy) * DIST_BITS'(dy);
      return px + py;
   endfunction

   task automatic clear_candidates();
      exact_hit   = 1'b0;
      exact_x     = '0;
      exact_y     = '0;
      person_hit  = 1'b0;
      person_dist = '0;
      person_x    = '0;
      person_y    = '0;
      any_hit     = 1'b0;
      any_dist    = '0;
      any_x       = '0;
      any_y       = '0;
   endtask

   task automatic track_request(input req_type t);
      logic [DIST_BITS-1:0] sq_dist;
      rsp_type              pick;
      case (t.kind)
         KIND_START: begin
            want_person = t.query_person;
            want_side   = t.query_side;
            anchor_x    = t.near_x;
            anchor_y    = t.near_y;
            clear_candidates();
         end
         KIND_HAND: begin
            if (t.hand_finite) begin
               sq_dist = squared_distance(t.hand_x, t.hand_y, anchor_x, anchor_y);
               if (t.hand_person == want_person && t.hand_side == want_side
                   && !exact_hit) begin
                  exact_hit = 1'b1;
                  exact_x   = t.hand_x;
                  exact_y   = t.hand_y;
               end
               if (t.hand_person == want_person && (!person_hit || sq_dist < person_dist)) begin
                  person_hit  = 1'b1;
                  person_dist = sq_dist;
                  person_x    = t.hand_x;
                  person_y    = t.hand_y;
               end
               if (!any_hit || sq_dist < any_dist) begin
                  any_hit  = 1'b1;
                  any_dist = sq_dist;
                  any_x    = t.hand_x;
                  any_y    = t.hand_y;
               end
            end
         end
         KIND_END: begin
            pick = '0;
            if (exact_hit) begin
               pick.found      = 1'b1;
               pick.center_x   = exact_x;
               pick.center_y   = exact_y;
               pick.match_tier = TIER_EXACT;
            end else if (person_hit) begin
               pick.found      = 1'b1;
               pick.center_x   = person_x;
               pick.center_y   = person_y;
               pick.match_tier = TIER_PERSON;
            end else if (any_hit) begin
               pick.found      = 1'b1;
               pick.center_x   = any_x;
               pick.center_y   = any_y;
               pick.match_tier = TIER_ANY;
            end else begin
               pick.match_tier = TIER_NONE;
            end
            selection_queue.push_back(pick);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         want_person = '0;
         want_side   = '0;
         anchor_x    = '0;
         anchor_y    = '0;
         clear_candidates();
         selection_queue.delete();
      end else begin
         if (req_valid && req_ready) begin
            track_request(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            if (selection_queue.size() == 0) begin
               $error("unexpected rsp transaction: found %0d center_x %0d center_y %0d tier %0d",
                      rsp_payload.found, rsp_payload.center_x, rsp_payload.center_y,
                      rsp_payload.match_tier);
               fail_count++;
            end else begin
               want = selection_queue.pop_front();
               if (rsp_payload.found !== want.found) begin
                  $error("found: expected %0d actual %0d", want.found, rsp_payload.found);
                  fail_count++;
               end
               if (rsp_payload.center_x !== want.center_x) begin
                  $error("center_x: expected %0d actual %0d",
                         want.center_x, rsp_payload.center_x);
                  fail_count++;
               end
               if (rsp_payload.center_y !== want.center_y) begin
                  $error("center_y: expected %0d actual %0d",
                         want.center_y, rsp_payload.center_y);
                  fail_count++;
               end
               if (rsp_payload.match_tier !== want.match_tier) begin
                  $error("match_tier: expected %0d actual %0d",
                         want.match_tier, rsp_payload.match_tier);
                  fail_count++;
               end
            end
         end
      end
      pending_count = selection_queue.size();
   end

endmodule

// ===== dv/tiered_nearest_hand_select_core_tb.sv =====
// ============================================================================
// Tiered nearest hand select core testbench
// Drives directed and random query sequences with random idle bursts on both
// channels; the result checker predicts and compares every rsp transaction.
// ============================================================================
module tiered_nearest_hand_select_core_tb;
   import tnhs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 450;
   localparam int CALM_ITEMS   = 400;
   localparam int REQ_BITS     = $bits(req_type);

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;
   int      fail_count;
   int      pending_count;
   int      items_sent  = 0;
   bit      calm        = 1'b0;
   int      stall_left  = 0;

   localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   always #6 clock = ~clock;

   tiered_nearest_hand_select_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   tnhs_result_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 10);
         end
      end
   end

   function automatic req_type noise_req(input logic [KIND_BITS-1:0] kind);
      req_type t;
      t = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
      t.kind = kind;
      return t;
   endfunction

   function automatic req_type start_req(input logic [PERSON_BITS-1:0] p,
                                         input logic [SIDE_BITS-1:0] s,
                                         input logic signed [COORD_BITS-1:0] x,
                                         input logic signed [COORD_BITS-1:0] y);
      req_type t;
      t = noise_req(KIND_START);
      t.query_person = p;
      t.query_side   = s;
      t.near_x       = x;
      t.near_y       = y;
      return t;
   endfunction

   function automatic req_type hand_req(input logic [PERSON_BITS-1:0] p,
                                        input logic [SIDE_BITS-1:0] s,
                                        input logic signed [COORD_BITS-1:0] x,
                                        input logic signed [COORD_BITS-1:0] y,
                                        input logic f);
      req_type t;
      t = noise_req(KIND_HAND);
      t.hand_person = p;
      t.hand_side   = s;
      t.hand_x      = x;
      t.hand_y      = y;
      t.hand_finite = f;
      return t;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return COORD_BITS'($urandom);
         1: return CMAX;
         2: return CMIN;
         default: return COORD_BITS'($signed($urandom_range(0, 127)) - 64);
      endcase
   endfunction

   function automatic logic [PERSON_BITS-1:0] pick_person();
      if ($urandom_range(0, 1) == 0) begin
         return PERSON_BITS'($urandom_range(0, 3));
      end
      return PERSON_BITS'($urandom);
   endfunction

   // Sending starts at a falling edge and returns at the falling edge after
   // acceptance with valid still high for the next item, or after an idle gap.
   task automatic send(input req_type t);
      req_valid   <= 1'b1;
      req_payload <= t;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
      if (t.kind != KIND_UNUSED) begin
         items_sent++;
      end
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic random_query();
      logic [PERSON_BITS-1:0] p;
      logic [SIDE_BITS-1:0]   s;
      int                     n;
      p = pick_person();
      s = SIDE_BITS'($urandom_range(0, 3));
      send(start_req(p, s, pick_coord(), pick_coord()));
      n = $urandom_range(0, 8);
      repeat (n) begin
         send(hand_req($urandom_range(0, 1) ? p : pick_person(),
                       $urandom_range(0, 1) ? s : SIDE_BITS'($urandom_range(0, 3)),
                       pick_coord(), pick_coord(), $urandom_range(0, 7) != 0));
      end
      send(noise_req(KIND_END));
      if ($urandom_range(0, 5) == 0) begin
         send(noise_req(KIND_END));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send(noise_req(KIND_END));
      send(hand_req(16'h0000, 2'd0, 24'sd10, 24'sd20, 1'b1));
      send(hand_req(16'h0000, 2'd1, 24'sd1, 24'sd1, 1'b1));
      send(noise_req(KIND_END));
      send(noise_req(KIND_END));
      send(noise_req(KIND_UNUSED));
      send(start_req(16'hFFFF, 2'd3, CMAX, CMIN));
      send(hand_req(16'hFFFF, 2'd2, CMIN, CMAX, 1'b1));
      send(hand_req(16'h1234, 2'd3, CMAX, CMIN, 1'b1));
      send(hand_req(16'hFFFF, 2'd3, 24'sd0, 24'sd0, 1'b0));
      send(noise_req(KIND_END));
      send(hand_req(16'hFFFF, 2'd3, 24'sd0, 24'sd0, 1'b1));
      send(noise_req(KIND_END));
      send(start_req(16'h00AA, 2'd2, 24'sd0, 24'sd0));
      send(hand_req(16'h0001, 2'd2, 24'sd3, 24'sd4, 1'b1));
      send(hand_req(16'h0002, 2'd2, -24'sd4, 24'sd3, 1'b1));
      send(hand_req(16'h0003, 2'd0, 24'sd5, 24'sd0, 1'b1));
      send(noise_req(KIND_END));
      send(hand_req(16'h00AA, 2'd1, 24'sd0, 24'sd5, 1'b1));
      send(hand_req(16'h00AA, 2'd0, -24'sd5, 24'sd0, 1'b1));
      send(noise_req(KIND_END));
      send(start_req(16'h5555, 2'd1, 24'sd7, -24'sd7));
      send(hand_req(16'h5555, 2'd1, 24'sd7, -24'sd7, 1'b0));
      send(noise_req(KIND_END));

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= CALM_ITEMS) begin
            calm = 1'b1;
         end
         case ($urandom_range(0, 9))
            8: begin
               send(noise_req($urandom_range(0, 1) ? KIND_UNUSED : KIND_HAND));
            end
            9: begin
               send(noise_req(KIND_END));
            end
            default: begin
               random_query();
            end
         endcase
      end
      req_valid <= 1'b0;

      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("tiered_nearest_hand_select_core regression: pass");
      end else begin
         $display("tiered_nearest_hand_select_core regression: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tiered_nearest_hand_select_core regression: fail");
      $finish;
   end

endmodule
